FILE: rtl/bdsv_pkg.sv
`timescale 1ns / 1ps
package bdsv_pkg;

	typedef enum logic [3:0] {
		OP_HMOD,
		OP_TUPD,
		OP_U1,
		OP_RMOD,
		OP_U2,
		OP_AMOD,
		OP_YMOD,
		OP_MULACC,
		OP_SQ,
		OP_XPROD,
		OP_VMOD
	} mm_op_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_CHKQ,
		ST_EUC,
		ST_DIV,
		ST_ISSUE,
		ST_WAIT,
		ST_EXP,
		ST_FIN
	} ctrl_state_t;

	typedef enum logic [1:0] {
		REG_MODULUS_P   = 2'd0,
		REG_ORDER_Q     = 2'd1,
		REG_GENERATOR_A = 2'd2,
		REG_PUBLIC_KEY  = 2'd3
	} cfg_reg_t;

	typedef struct packed {
		logic   load;
		logic   mm_start;
		mm_op_t op;
		logic   div_start;
		logic   inv_set;
		logic   exp_init;
		logic   exp_phase;
		logic   finish;
	} dp_cmd_t;

	typedef struct packed {
		logic mm_done;
		logic div_done;
		logic q_zero;
		logic p_zero;
		logic g1_zero;
		logic e_zero;
		logic e_lsb;
		logic out_busy;
	} dp_status_t;

endpackage

FILE: rtl/bytewise_dsa_signature_verify_unit.sv
`timescale 1ns / 1ps
// Channel  Handshake          Payload
// in       in_valid/in_stall  sig_r, sig_elem, digest_byte, last_elem
// out      out_valid/out_stall elem_match, sig_done, sig_valid
// cfg      cfg_valid/cfg_ready cfg_index, cfg_data
//
// One element at a time. Every modular multiply runs in a single shared shift-add unit of
// width W = max(P_WIDTH,16); the work for an element grows with the Euclid steps and
// with the bit lengths and popcounts of u1 and u2.
// Reset clears the configuration registers, element count and fail flag.
// A finished result waits in the output register; the next element is taken once it
// is loaded there, and an output stall holds the block only at the end of an element.
module bytewise_dsa_signature_verify_unit #(
	parameter int DIGEST_BYTES = 32,
	parameter int P_WIDTH      = 32,
	parameter int Q_WIDTH      = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [15:0] sig_r,
	input  logic [15:0] sig_elem,
	input  logic [7:0]  digest_byte,
	input  logic        last_elem,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        elem_match,
	output logic        sig_done,
	output logic        sig_valid
);
	import bdsv_pkg::*;

	dp_cmd_t    cmd;
	dp_status_t st;

	assign cfg_ready = 1'b1;

	bdsv_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.st       (st),
		.cmd      (cmd)
	);

	bdsv_dp #(
		.DIGEST_BYTES (DIGEST_BYTES),
		.P_WIDTH      (P_WIDTH),
		.Q_WIDTH      (Q_WIDTH)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_valid   (cfg_valid),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.sig_r       (sig_r),
		.sig_elem    (sig_elem),
		.digest_byte (digest_byte),
		.last_elem   (last_elem),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.elem_match  (elem_match),
		.sig_done    (sig_done),
		.sig_valid   (sig_valid),
		.cmd         (cmd),
		.st          (st)
	);
endmodule

FILE: rtl/bdsv_mulmod.sv
`timescale 1ns / 1ps
module bdsv_mulmod #(
	parameter int W = 32
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         start,
	input  logic [W-1:0] opa,
	input  logic [W-1:0] opb,
	input  logic [W-1:0] modulus,
	output logic         done,
	output logic [W-1:0] res
);
	localparam int CW = $clog2(W + 1);

	logic [W-1:0]  asr_q;
	logic [W-1:0]  acc_q;
	logic [W-1:0]  b_q;
	logic [W-1:0]  m_q;
	logic [CW-1:0] cnt_q;
	logic          busy_q;
	logic          done_q;
	logic [W:0]    dbl;
	logic [W:0]    dbl_r;
	logic [W:0]    sum;
	logic [W:0]    sum_r;
	logic [W-1:0]  acc_d;

	// Horner form: acc = 2*acc (+ b), the doubling and the add each folded back below m by one subtract.
	always_comb begin
		dbl   = {acc_q, 1'b0};
		dbl_r = (dbl >= {1'b0, m_q}) ? dbl - {1'b0, m_q} : dbl;
		sum   = dbl_r + {1'b0, b_q};
		sum_r = (sum >= {1'b0, m_q}) ? sum - {1'b0, m_q} : sum;
		acc_d = asr_q[W-1] ? sum_r[W-1:0] : dbl_r[W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			asr_q <= opa;
			b_q   <= opb;
			m_q   <= modulus;
			acc_q <= '0;
		end else if (busy_q) begin
			asr_q <= {asr_q[W-2:0], 1'b0};
			acc_q <= acc_d;
		end
	end

	assign done = done_q;
	assign res  = acc_q;
endmodule

FILE: rtl/bdsv_div.sv
`timescale 1ns / 1ps
module bdsv_div #(
	parameter int N = 16
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         start,
	input  logic [N-1:0] dividend,
	input  logic [N-1:0] divisor,
	output logic         done,
	output logic [N-1:0] quo,
	output logic [N-1:0] rem
);
	localparam int CW = $clog2(N + 1);

	logic [N-1:0]  nsr_q;
	logic [N-1:0]  d_q;
	logic [N-1:0]  quo_q;
	logic [N-1:0]  rem_q;
	logic [CW-1:0] cnt_q;
	logic          busy_q;
	logic          done_q;
	logic [N:0]    trial;
	logic          fits;

	always_comb begin
		trial = {rem_q, nsr_q[N-1]};
		fits  = trial >= {1'b0, d_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(N);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			nsr_q <= dividend;
			d_q   <= divisor;
			quo_q <= '0;
			rem_q <= '0;
		end else if (busy_q) begin
			nsr_q <= {nsr_q[N-2:0], 1'b0};
			quo_q <= {quo_q[N-2:0], fits};
			rem_q <= fits ? N'(trial - {1'b0, d_q}) : trial[N-1:0];
		end
	end

	assign done = done_q;
	assign quo  = quo_q;
	assign rem  = rem_q;
endmodule

FILE: rtl/bdsv_ctrl.sv
`timescale 1ns / 1ps
module bdsv_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  bdsv_pkg::dp_status_t st,
	output bdsv_pkg::dp_cmd_t    cmd
);
	import bdsv_pkg::*;

	ctrl_state_t state_q, state_d;
	mm_op_t      op_q, op_d;
	logic        phase_q, phase_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			op_q    <= OP_HMOD;
			phase_q <= 1'b0;
		end else begin
			state_q <= state_d;
			op_q    <= op_d;
			phase_q <= phase_d;
		end
	end

	always_comb begin
		state_d = state_q;
		op_d    = op_q;
		phase_d = phase_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					state_d = ST_CHKQ;
					phase_d = 1'b0;
				end
			end
			ST_CHKQ: begin
				if (st.q_zero) begin
					state_d = ST_FIN;
				end else begin
					op_d    = OP_HMOD;
					state_d = ST_ISSUE;
				end
			end
			ST_EUC: begin
				if (st.g1_zero) begin
					op_d    = OP_U1;
					state_d = ST_ISSUE;
				end else begin
					state_d = ST_DIV;
				end
			end
			ST_DIV: begin
				if (st.div_done) begin
					op_d    = OP_TUPD;
					state_d = ST_ISSUE;
				end
			end
			ST_ISSUE: state_d = ST_WAIT;
			ST_WAIT: begin
				if (st.mm_done) begin
					unique case (op_q)
						OP_HMOD, OP_TUPD: state_d = ST_EUC;
						OP_U1: begin
							op_d    = OP_RMOD;
							state_d = ST_ISSUE;
						end
						OP_RMOD: begin
							op_d    = OP_U2;
							state_d = ST_ISSUE;
						end
						OP_U2: begin
							if (st.p_zero) begin
								state_d = ST_FIN;
							end else begin
								op_d    = OP_AMOD;
								state_d = ST_ISSUE;
							end
						end
						OP_AMOD, OP_YMOD, OP_SQ: state_d = ST_EXP;
						OP_MULACC: begin
							op_d    = OP_SQ;
							state_d = ST_ISSUE;
						end
						OP_XPROD: begin
							op_d    = OP_VMOD;
							state_d = ST_ISSUE;
						end
						OP_VMOD: state_d = ST_FIN;
						default: state_d = ST_FIN;
					endcase
				end
			end
			ST_EXP: begin
				state_d = ST_ISSUE;
				if (st.e_zero) begin
					if (!phase_q) begin
						op_d    = OP_YMOD;
						phase_d = 1'b1;
					end else begin
						op_d = OP_XPROD;
					end
				end else if (st.e_lsb) begin
					op_d = OP_MULACC;
				end else begin
					op_d = OP_SQ;
				end
			end
			ST_FIN: begin
				if (!st.out_busy) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd           = '0;
		cmd.op        = op_q;
		in_stall      = (state_q != ST_IDLE);
		cmd.exp_phase = (op_q == OP_YMOD);
		unique case (state_q)
			ST_IDLE:  cmd.load = in_valid;
			ST_EUC:   cmd.inv_set = st.g1_zero;
			ST_DIV:   cmd.div_start = 1'b0;
			ST_ISSUE: cmd.mm_start = 1'b1;
			ST_WAIT:  cmd.exp_init = st.mm_done && (op_q == OP_AMOD || op_q == OP_YMOD);
			ST_FIN:   cmd.finish = !st.out_busy;
			default:  cmd.load = 1'b0;
		endcase
		// The divider is started on entry to the division state.
		cmd.div_start = (state_q == ST_EUC) && !st.g1_zero;
	end
endmodule

FILE: rtl/bdsv_dp.sv
`timescale 1ns / 1ps
module bdsv_dp #(
	parameter int DIGEST_BYTES = 32,
	parameter int P_WIDTH      = 32,
	parameter int Q_WIDTH      = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_valid,
	input  logic [1:0]           cfg_index,
	input  logic [31:0]          cfg_data,
	input  logic [15:0]          sig_r,
	input  logic [15:0]          sig_elem,
	input  logic [7:0]           digest_byte,
	input  logic                 last_elem,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic                 elem_match,
	output logic                 sig_done,
	output logic                 sig_valid,
	input  bdsv_pkg::dp_cmd_t    cmd,
	output bdsv_pkg::dp_status_t st
);
	import bdsv_pkg::*;

	localparam int W = (P_WIDTH > 16) ? P_WIDTH : 16;

	logic [P_WIDTH-1:0] p_q, a_q, y_q;
	logic [Q_WIDTH-1:0] q_q;
	logic [15:0]        r_q, s_q;
	logic [7:0]         h_q;
	logic               last_q;

	logic [Q_WIDTH-1:0] g0_q, g1_q, t0_q, t1_q, quo_q, rem_q;
	logic [Q_WIDTH-1:0] inv_q, u1_q, u2_q, rq_q, e_q, v_q;
	logic [W-1:0]       b_q, acc_q, x1_q, prod_q;
	mm_op_t             mop_q;

	logic [5:0]         count_q;
	logic               fail_q;
	logic               out_valid_q, match_q, done_q, verdict_q;

	logic [W-1:0]       qw, pw, one_q, one_p;
	logic [W-1:0]       mm_a, mm_b, mm_m, mm_res;
	logic [Q_WIDTH-1:0] nr, mm_rq, tnew;
	logic [Q_WIDTH:0]   tsum;
	logic               mm_done, div_done;
	logic [Q_WIDTH-1:0] div_quo, div_rem;
	logic               match, bad;
	logic [6:0]         cnt_next;

	always_comb begin
		qw    = W'(q_q);
		pw    = W'(p_q);
		one_q = {{(W-1){1'b0}}, (q_q != Q_WIDTH'(1))};
		one_p = {{(W-1){1'b0}}, (p_q != P_WIDTH'(1))};
		nr    = (rq_q == '0) ? '0 : q_q - rq_q;
		mm_a  = '0;
		mm_b  = one_q;
		mm_m  = qw;
		unique case (cmd.op)
			OP_HMOD:  mm_a = W'(h_q);
			OP_TUPD: begin
				mm_a = W'(quo_q);
				mm_b = W'(t1_q);
			end
			OP_U1: begin
				mm_a = W'(s_q);
				mm_b = W'(inv_q);
			end
			OP_RMOD:  mm_a = W'(r_q);
			OP_U2: begin
				mm_a = W'(nr);
				mm_b = W'(inv_q);
			end
			OP_AMOD: begin
				mm_a = W'(a_q);
				mm_b = one_p;
				mm_m = pw;
			end
			OP_YMOD: begin
				mm_a = W'(y_q);
				mm_b = one_p;
				mm_m = pw;
			end
			OP_MULACC: begin
				mm_a = acc_q;
				mm_b = b_q;
				mm_m = pw;
			end
			OP_SQ: begin
				mm_a = b_q;
				mm_b = b_q;
				mm_m = pw;
			end
			OP_XPROD: begin
				mm_a = x1_q;
				mm_b = acc_q;
				mm_m = pw;
			end
			OP_VMOD:  mm_a = prod_q;
			default:  mm_a = '0;
		endcase
	end

	bdsv_mulmod #(.W(W)) u_mulmod (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (cmd.mm_start),
		.opa     (mm_a),
		.opb     (mm_b),
		.modulus (mm_m),
		.done    (mm_done),
		.res     (mm_res)
	);

	bdsv_div #(.N(Q_WIDTH)) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (g0_q),
		.divisor  (g1_q),
		.done     (div_done),
		.quo      (div_quo),
		.rem      (div_rem)
	);

	// Bezout coefficients are kept reduced mod q, so the update is a modular subtract.
	always_comb begin
		mm_rq = mm_res[Q_WIDTH-1:0];
		tsum  = {1'b0, t0_q} + {1'b0, q_q};
		tnew  = (t0_q >= mm_rq) ? t0_q - mm_rq : Q_WIDTH'(tsum - {1'b0, mm_rq});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			p_q <= '0;
			q_q <= '0;
			a_q <= '0;
			y_q <= '0;
		end else if (cfg_valid) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_MODULUS_P:   p_q <= cfg_data[P_WIDTH-1:0];
				REG_ORDER_Q:     q_q <= cfg_data[Q_WIDTH-1:0];
				REG_GENERATOR_A: a_q <= cfg_data[P_WIDTH-1:0];
				REG_PUBLIC_KEY:  y_q <= cfg_data[P_WIDTH-1:0];
				default:         p_q <= p_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			r_q    <= sig_r;
			s_q    <= sig_elem;
			h_q    <= digest_byte;
			last_q <= last_elem;
			v_q    <= '0;
		end
		if (cmd.mm_start) begin
			mop_q <= cmd.op;
		end
		if (div_done) begin
			quo_q <= div_quo;
			rem_q <= div_rem;
		end
		if (cmd.inv_set) begin
			inv_q <= (g0_q == Q_WIDTH'(1)) ? t0_q : '0;
		end
		if (cmd.exp_init) begin
			e_q   <= cmd.exp_phase ? u2_q : u1_q;
			acc_q <= one_p;
			if (cmd.exp_phase) begin
				x1_q <= acc_q;
			end
		end
		if (mm_done) begin
			case (mop_q)
				OP_HMOD: begin
					g1_q <= mm_rq;
					g0_q <= q_q;
					t0_q <= '0;
					t1_q <= one_q[Q_WIDTH-1:0];
				end
				OP_TUPD: begin
					g0_q <= g1_q;
					g1_q <= rem_q;
					t0_q <= t1_q;
					t1_q <= tnew;
				end
				OP_U1:     u1_q <= mm_rq;
				OP_RMOD:   rq_q <= mm_rq;
				OP_U2:     u2_q <= mm_rq;
				OP_AMOD, OP_YMOD: b_q <= mm_res;
				OP_MULACC: acc_q <= mm_res;
				OP_SQ: begin
					b_q <= mm_res;
					e_q <= e_q >> 1;
				end
				OP_XPROD:  prod_q <= mm_res;
				OP_VMOD:   v_q <= mm_rq;
				default:   v_q <= v_q;
			endcase
		end
	end

	always_comb begin
		match    = (q_q != '0) && (16'(v_q) == r_q);
		bad      = (r_q == '0) || (r_q >= 16'(q_q)) || (s_q >= 16'(q_q)) || !match;
		cnt_next = {1'b0, count_q} + 7'd1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			fail_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			if (cmd.finish) begin
				out_valid_q <= 1'b1;
				if (last_q) begin
					count_q <= '0;
					fail_q  <= 1'b0;
				end else begin
					if (bad || cnt_next >= 7'(DIGEST_BYTES)) begin
						fail_q <= 1'b1;
					end
					if (count_q != 6'd63) begin
						count_q <= count_q + 6'd1;
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			match_q   <= match;
			done_q    <= last_q;
			verdict_q <= last_q && !fail_q && !bad && (cnt_next == 7'(DIGEST_BYTES));
		end
	end

	always_comb begin
		st.mm_done  = mm_done;
		st.div_done = div_done;
		st.q_zero   = (q_q == '0);
		st.p_zero   = (p_q == '0);
		st.g1_zero  = (g1_q == '0);
		st.e_zero   = (e_q == '0);
		st.e_lsb    = e_q[0];
		st.out_busy = out_valid_q && out_stall;
	end

	assign out_valid  = out_valid_q;
	assign elem_match = match_q;
	assign sig_done   = done_q;
	assign sig_valid  = verdict_q;
endmodule

FILE: tb/bytewise_dsa_signature_verify_unit_tb.sv
`timescale 1ns / 1ps
module bytewise_dsa_signature_verify_unit_tb;
	import bdsv_pkg::*;

	localparam int SIG_BYTES = 32;

	logic        clk;
	logic        arst_n;
	logic        cfg_valid;
	logic        cfg_ready;
	cfg_reg_t    cfg_index;
	logic [31:0] cfg_data;
	logic        in_valid;
	logic        in_stall;
	logic [15:0] sig_r;
	logic [15:0] sig_elem;
	logic [7:0]  digest_byte;
	logic        last_elem;
	logic        out_valid;
	logic        out_stall;
	logic        elem_match;
	logic        sig_done;
	logic        sig_valid;

	bytewise_dsa_signature_verify_unit i_dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_stall(in_stall), .sig_r(sig_r), .sig_elem(sig_elem),
		.digest_byte(digest_byte), .last_elem(last_elem),
		.out_valid(out_valid), .out_stall(out_stall), .elem_match(elem_match),
		.sig_done(sig_done), .sig_valid(sig_valid)
	);

	function automatic longint unsigned pow_mod(longint unsigned b, longint unsigned e,
			longint unsigned m);
		longint unsigned acc;
		if (m == 0) return 0;
		acc = 1 % m;
		b = b % m;
		while (e != 0) begin
			if (e[0]) acc = (acc * b) % m;
			b = (b * b) % m;
			e = e >> 1;
		end
		return acc;
	endfunction

	// Extended Euclid; no inverse (or a zero order) gives 0.
	function automatic longint unsigned inv_mod(longint unsigned h, longint unsigned q);
		longint g0, g1, t0, t1, quo, tmp;
		if (q == 0) return 0;
		g0 = q;
		g1 = h % q;
		t0 = 0;
		t1 = 1;
		while (g1 != 0) begin
			quo = g0 / g1;
			tmp = g0 - quo * g1;
			g0 = g1;
			g1 = tmp;
			tmp = t0 - quo * t1;
			t0 = t1;
			t1 = tmp;
		end
		if (g0 != 1) return 0;
		if (t0 < 0) t0 += q;
		return longint'(t0) % q;
	endfunction

	function automatic bit is_prime(longint unsigned n);
		longint unsigned i;
		if (n < 2) return 0;
		if (n % 2 == 0) return n == 2;
		for (i = 3; i * i <= n; i += 2)
			if (n % i == 0) return 0;
		return 1;
	endfunction

	typedef struct {
		bit match;
		bit done;
		bit verdict;
	} elem_verdict_t;

	class sig_scoreboard;
		bit [31:0] p_mod, a_gen, y_key;
		bit [15:0] q_ord;
		int unsigned elem_cnt;
		bit          failed;
		elem_verdict_t pending_q[$];
		int errors, checked, sigs_ok, sigs_seen;

		function void write_reg(cfg_reg_t idx, bit [31:0] d);
			case (idx)
				REG_MODULUS_P:   p_mod = d;
				REG_ORDER_Q:     q_ord = d[15:0];
				REG_GENERATOR_A: a_gen = d;
				REG_PUBLIC_KEY:  y_key = d;
			endcase
		endfunction

		function void note_input(bit [15:0] r, bit [15:0] s, bit [7:0] h, bit l);
			elem_verdict_t e;
			longint unsigned inv, u1, u2, v, q, p;
			bit bad;
			q = q_ord;
			p = p_mod;
			e.match = 0;
			e.done = l;
			e.verdict = 0;
			if (q != 0) begin
				inv = inv_mod(h, q);
				u1 = (s * inv) % q;
				u2 = (((q - (r % q)) % q) * inv) % q;
				v = 0;
				if (p != 0)
					v = ((pow_mod(a_gen, u1, p) * pow_mod(y_key, u2, p)) % p) % q;
				e.match = (v == r);
			end
			bad = (r == 0) || (r >= q) || (s >= q) || !e.match;
			if (l) begin
				e.verdict = !failed && !bad && (elem_cnt + 1 == SIG_BYTES);
				elem_cnt = 0;
				failed = 0;
			end else begin
				if (bad || elem_cnt + 1 >= SIG_BYTES) failed = 1;
				if (elem_cnt < 63) elem_cnt++;
			end
			pending_q.push_back(e);
		endfunction

		function void check_result(bit m, bit d, bit v);
			elem_verdict_t e;
			if (pending_q.size() == 0) begin
				$error("result beat with no expectation: elem_match=%0d sig_done=%0d sig_valid=%0d",
					m, d, v);
				errors++;
				return;
			end
			e = pending_q.pop_front();
			checked++;
			if (m !== e.match) begin
				$error("elem_match: expected %0d, got %0d", e.match, m);
				errors++;
			end
			if (d !== e.done) begin
				$error("sig_done: expected %0d, got %0d", e.done, d);
				errors++;
			end
			if (v !== e.verdict) begin
				$error("sig_valid: expected %0d, got %0d", e.verdict, v);
				errors++;
			end
			if (e.done) sigs_seen++;
			if (e.done && e.verdict) sigs_ok++;
		endfunction
	endclass

	sig_scoreboard sb;
	bit  calm;
	int  hold_len;
	int  items_sent;
	longint unsigned g_p, g_q, g_a, g_x, g_y;

	initial begin
		clk = 0;
		forever #1 clk = ~clk;
	end

	initial begin
		#40000000;
		$display("FAILURE");
		$finish;
	end

	// Receiver: random stalls, plus one long hold-off on request.
	initial begin
		out_stall = 0;
		forever begin
			@(posedge clk);
			if (hold_len > 0) begin
				out_stall <= 1;
				repeat (hold_len) @(posedge clk);
				hold_len = 0;
			end else begin
				out_stall <= !calm && ($urandom_range(99) < 28);
			end
		end
	end

	always @(posedge clk)
		if (arst_n && out_valid && !out_stall)
			sb.check_result(elem_match, sig_done, sig_valid);

	task automatic send_item(bit [15:0] r, bit [15:0] s, bit [7:0] h, bit l);
		if (!calm && $urandom_range(99) < 28) begin
			in_valid <= 0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
		in_valid    <= 1;
		sig_r       <= r;
		sig_elem    <= s;
		digest_byte <= h;
		last_elem   <= l;
		do @(posedge clk); while (in_stall);
		sb.note_input(r, s, h, l);
		items_sent++;
	endtask

	task automatic drain();
		int guard;
		guard = 0;
		in_valid <= 0;
		while (sb.pending_q.size() != 0 && guard < 400000) begin
			@(posedge clk);
			guard++;
		end
	endtask

	task automatic write_cfg(cfg_reg_t idx, bit [31:0] d);
		cfg_valid <= 1;
		cfg_index <= idx;
		cfg_data  <= d;
		do @(posedge clk); while (!cfg_ready);
		sb.write_reg(idx, d);
	endtask

	// Upper bits of the order write are random to exercise the width mask.
	task automatic set_regs(bit [31:0] p, bit [15:0] q, bit [31:0] a, bit [31:0] y);
		drain();
		write_cfg(REG_MODULUS_P, p);
		write_cfg(REG_ORDER_Q, {16'($urandom), q});
		write_cfg(REG_GENERATOR_A, a);
		write_cfg(REG_PUBLIC_KEY, y);
		cfg_valid <= 0;
	endtask

	task automatic load_group(longint unsigned p, longint unsigned q);
		longint unsigned gb;
		gb = 2;
		g_p = p;
		g_q = q;
		forever begin
			g_a = pow_mod(gb, (p - 1) / q, p);
			if (g_a != 1) break;
			gb++;
		end
		g_x = $urandom_range(q - 1, 1);
		g_y = pow_mod(g_a, g_x, p);
		set_regs(p, q, g_a, g_y);
	endtask

	// kind: 0-5 well formed, 6 one bad element, 7 random length of 28 to 40, 8 noise,
	// 9 bad r, 10 an overlong run that saturates the element count.
	task automatic send_sig(int kind);
		int n, bad_at, i;
		longint unsigned k, r, s;
		bit [7:0] h;
		if (kind == 8) begin
			n = $urandom_range(5, 1);
			for (i = 0; i < n; i++)
				send_item(16'($urandom), 16'($urandom), 8'($urandom), 1'($urandom_range(1)));
			return;
		end
		n = SIG_BYTES;
		if (kind == 7) n = $urandom_range(40, 28);
		if (kind == 10) n = 70;
		do begin
			k = $urandom_range(g_q - 1, 1);
			r = pow_mod(g_a, k, g_p) % g_q;
		end while (r == 0);
		bad_at = (kind == 6) ? int'($urandom_range(n - 1)) : -1;
		for (i = 0; i < n; i++) begin
			do h = 8'($urandom); while (h % g_q == 0);
			s = (g_x * r + k * h) % g_q;
			if (i == bad_at) s = (s + 1) % g_q;
			if (kind == 9)
				send_item(16'(($urandom_range(1) && r + g_q <= 16'hFFFF) ? r + g_q : 0),
					16'(s), h, i == n - 1);
			else
				send_item(16'(r), 16'(s), h, i == n - 1);
		end
	endtask

	initial begin
		int sel, j;
		longint unsigned bq, bm, bp;
		sb = new();
		arst_n      = 0;
		cfg_valid   = 0;
		cfg_index   = REG_MODULUS_P;
		cfg_data    = 0;
		in_valid    = 0;
		sig_r       = 0;
		sig_elem    = 0;
		digest_byte = 0;
		last_elem   = 0;
		calm        = 0;
		hold_len    = 0;
		items_sent  = 0;
		repeat (10) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// Registers still at reset: zero order and zero modulus.
		send_item(0, 0, 0, 0);
		send_item(16'hFFFF, 16'hFFFF, 8'hFF, 1);
		send_item(1, 1, 1, 1);

		// All registers at their maximum.
		set_regs(32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_item(0, 5, 8'hFF, 0);
		send_item(16'hFFFF, 16'hFFFF, 8'hFF, 0);
		send_item(16'h1234, 16'h0001, 8'h00, 0);
		send_item(16'h0001, 16'h0000, 8'h01, 0);
		send_item(16'h8000, 16'h7FFF, 8'h80, 1);

		// Zero modulus with a live order.
		set_regs(0, 11, 2, 3);
		send_item(0, 0, 1, 0);
		send_item(5, 3, 8'hFF, 0);
		send_item(1, 10, 11, 1);

		// A full-size group found at run time.
		do bq = $urandom_range(65535, 40000); while (!is_prime(bq));
		bm = ((64'd1 << 31) / bq + $urandom_range(1000)) & ~64'd1;
		do begin
			bp = bq * bm + 1;
			bm += 2;
		end while (!is_prime(bp));
		load_group(bp, bq);
		send_sig(0);
		send_sig(8);
		send_sig(6);

		// Long receiver hold-off while the sender keeps offering elements.
		load_group(263, 131);
		hold_len = 8000;
		send_sig(0);
		send_sig(10);

		calm = 1;
		load_group(47, 23);
		send_sig(0);
		send_sig(7);
		calm = 0;

		while (items_sent < 700) begin
			sel = $urandom_range(3);
			case (sel)
				0: load_group(23, 11);
				1: load_group(47, 23);
				2: load_group(263, 131);
				default: load_group(2039, 1019);
			endcase
			for (j = 0; j < 3 && items_sent < 700; j++)
				send_sig(($urandom_range(99) < 60) ? $urandom_range(5) : $urandom_range(10, 6));
		end

		drain();
		repeat (200) @(posedge clk);
		if (sb.pending_q.size() != 0) begin
			$error("%0d expected results never arrived", sb.pending_q.size());
			sb.errors++;
		end
		$display("Sent %0d elements, checked %0d results, %0d signature verdicts (%0d valid).",
			items_sent, sb.checked, sb.sigs_seen, sb.sigs_ok);
		if (sb.errors == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
